[sv/upoc_pkg.sv]
// ----------------------------------------------------------------------------
// upoc_pkg
// Constants, widths and the angle table shared by the point offset controller.
// ----------------------------------------------------------------------------
package upoc_pkg;

    // Trig unit number formats
    localparam int TRIG_Q    = 30;
    localparam int TRIG_OUT  = 14;
    localparam int XW        = 34;   // rotation x and y
    localparam int ZW        = 36;   // residual angle
    localparam int CW        = 18;   // cos and sin in Q14
    localparam int ANGLE_LEN = 24;

    localparam logic signed [XW-1:0] CORDIC_START = 34'sd652032874;
    localparam logic signed [ZW-1:0] PI_Q30       = 36'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30  = 36'sd1686629713;

    localparam logic signed [ZW-1:0] ANGLE_STEP [ANGLE_LEN] = '{
        36'sd843314856, 36'sd497837829, 36'sd263043836, 36'sd133525158,
        36'sd67021686,  36'sd33543515,  36'sd16775850,  36'sd8388437,
        36'sd4194282,   36'sd2097149,   36'sd1048575,   36'sd524287,
        36'sd262143,    36'sd131071,    36'sd65535,     36'sd32767,
        36'sd16383,     36'sd8191,      36'sd4095,      36'sd2047,
        36'sd1023,      36'sd511,       36'sd255,       36'sd127
    };

    // Register widths
    localparam int GW = 24;          // position gain
    localparam int BW = 19;          // point offset
    localparam int RW = BW + 1;      // divider partial remainder

    // Datapath widths
    localparam int SUMW  = 50;       // error sum before clipping
    localparam int ERR_W = 39;
    localparam int LO_W  = 20;       // low slice of the error for the split multiply
    localparam int PH_W  = 44;
    localparam int GX_W  = 64;
    localparam int VBF_W = 66;
    localparam int VB_W  = 48;
    localparam int PW    = 66;       // trig by velocity products
    localparam int PS_W  = 67;
    localparam int WW    = 53;       // turn rate numerator

    localparam logic signed [SUMW-1:0]  ERR_MAX = (SUMW'(1) <<< (ERR_W - 1)) - SUMW'(1);
    localparam logic signed [VBF_W-1:0] VB_MAX  = (VBF_W'(1) <<< (VB_W - 1)) - VBF_W'(1);

    // Configuration register map
    localparam int ADDR_W = 3;
    localparam logic [ADDR_W-1:0] ADDR_GAIN   = 3'h0;
    localparam logic [ADDR_W-1:0] ADDR_OFFSET = 3'h4;

    localparam logic [GW-1:0] GAIN_RESET   = 24'd131072;
    localparam logic [BW-1:0] OFFSET_RESET = 19'd16384;

endpackage

[sv/unicycle_point_offset_controller.sv]
// ----------------------------------------------------------------------------
// unicycle_point_offset_controller
// Point offset linearising controller for a unicycle robot: pose and desired
// point in, linear speed and turn rate out.
// ----------------------------------------------------------------------------
// Throughput is one transaction per cycle: the trig chain, nine arithmetic
// stages and the DATA_WIDTH-1 divider cells each take a new sample every cycle.
// A stalled result freezes the whole pipeline until it is taken.
// Reset clears every valid flag and loads the gain and offset defaults.
// ----------------------------------------------------------------------------
module unicycle_point_offset_controller
    import upoc_pkg::*;
#(
    parameter int DATA_WIDTH  = 32,
    parameter int FRAC_BITS   = 16,
    parameter int TRIG_STAGES = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // APB configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ADDR_W-1:0]            paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // Sample channel
    input  logic                         cmd_valid,
    output logic                         cmd_stall,
    input  logic signed [DATA_WIDTH-1:0] desired_x,
    input  logic signed [DATA_WIDTH-1:0] desired_y,
    input  logic signed [DATA_WIDTH-1:0] desired_vx,
    input  logic signed [DATA_WIDTH-1:0] desired_vy,
    input  logic signed [DATA_WIDTH-1:0] robot_x,
    input  logic signed [DATA_WIDTH-1:0] robot_y,
    input  logic signed [14:0]           robot_heading,
    // Result channel
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic signed [DATA_WIDTH-1:0] linear_speed,
    output logic signed [DATA_WIDTH-1:0] turn_rate,
    output logic                         saturated
);

    localparam int D     = DATA_WIDTH;
    localparam int QW    = D - 1;
    localparam int SHQ   = D - 1 - FRAC_BITS;
    localparam int PAY_W = 6 * D;
    localparam int SIDE_W = D + 3;

    localparam logic signed [PS_W-1:0] OUT_MAX = (PS_W'(1) <<< (D - 1)) - PS_W'(1);
    localparam logic signed [D-1:0]    OMAX_D  = {1'b0, {(D-1){1'b1}}};
    localparam logic signed [D-1:0]    OMIN_D  = {1'b1, {(D-1){1'b0}}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [GW-1:0] gain_reg;
    logic [BW-1:0] offset_reg;
    logic [BW-1:0] b_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= GAIN_RESET;
            offset_reg <= OFFSET_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr)
                ADDR_GAIN:   gain_reg   <= pwdata[GW-1:0];
                ADDR_OFFSET: offset_reg <= pwdata[BW-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_GAIN:   prdata = {{(32-GW){1'b0}}, gain_reg};
            ADDR_OFFSET: prdata = {{(32-BW){1'b0}}, offset_reg};
            default:     prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    // A zero offset behaves as one LSB.
    assign b_eff  = (offset_reg == '0) ? BW'(1) : offset_reg;

    // ------------------------------------------------------------------
    // Pipeline advance: everything moves unless the result is held.
    // ------------------------------------------------------------------
    logic res_valid_reg;
    logic adv;

    assign adv       = !(res_valid_reg && res_stall);
    assign cmd_stall = !adv;

    // ------------------------------------------------------------------
    // Heading fold and trig chain
    // ------------------------------------------------------------------
    logic                 c_vld  [TRIG_STAGES+1];
    logic signed [XW-1:0] c_x    [TRIG_STAGES+1];
    logic signed [XW-1:0] c_y    [TRIG_STAGES+1];
    logic signed [ZW-1:0] c_z    [TRIG_STAGES+1];
    logic                 c_flip [TRIG_STAGES+1];
    logic [PAY_W-1:0]     c_pay  [TRIG_STAGES+1];
    logic signed [ZW-1:0] z_raw;

    always_comb
    begin
        z_raw = {{(ZW-15-(TRIG_Q-12)){robot_heading[14]}}, robot_heading,
                 {(TRIG_Q-12){1'b0}}};
        c_flip[0] = 1'b0;
        c_z[0]    = z_raw;
        // Headings beyond a quarter turn are folded by half a turn.
        if (z_raw > HALF_PI_Q30)
        begin
            c_z[0]    = z_raw - PI_Q30;
            c_flip[0] = 1'b1;
        end
        else if (z_raw < -HALF_PI_Q30)
        begin
            c_z[0]    = z_raw + PI_Q30;
            c_flip[0] = 1'b1;
        end
    end

    assign c_vld[0] = cmd_valid;
    assign c_x[0]   = CORDIC_START;
    assign c_y[0]   = '0;
    assign c_pay[0] = {desired_x, desired_y, desired_vx, desired_vy, robot_x, robot_y};

    for (genvar i = 0; i < TRIG_STAGES; i++)
    begin : g_cordic
        upoc_cordic_cell #(
            .STAGE (i),
            .PAY_W (PAY_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .vld_in   (c_vld[i]),
            .x_in     (c_x[i]),
            .y_in     (c_y[i]),
            .z_in     (c_z[i]),
            .flip_in  (c_flip[i]),
            .pay_in   (c_pay[i]),
            .vld_out  (c_vld[i+1]),
            .x_out    (c_x[i+1]),
            .y_out    (c_y[i+1]),
            .z_out    (c_z[i+1]),
            .flip_out (c_flip[i+1]),
            .pay_out  (c_pay[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Arithmetic stages
    // ------------------------------------------------------------------
    logic                    vld1_reg, vld2_reg, vld3_reg, vld4_reg, vld5_reg;
    logic                    vld6_reg, vld7_reg, vld8_reg, vld9_reg;

    // Stage 1: cos and sin in Q14
    logic signed [XW-1:0]    xf, yf;
    logic signed [CW-1:0]    cos1_reg, sin1_reg, cos1_next, sin1_next;
    logic [PAY_W-1:0]        pay1_reg;

    always_comb
    begin
        xf = c_flip[TRIG_STAGES] ? -c_x[TRIG_STAGES] : c_x[TRIG_STAGES];
        yf = c_flip[TRIG_STAGES] ? -c_y[TRIG_STAGES] : c_y[TRIG_STAGES];
        cos1_next = CW'(xf >>> (TRIG_Q - TRIG_OUT));
        sin1_next = CW'(yf >>> (TRIG_Q - TRIG_OUT));
    end

    // Stage 2: offset products
    logic signed [2*CW+1:0]  bc2_reg, bs2_reg;
    logic signed [CW-1:0]    cos2_reg, sin2_reg;
    logic [PAY_W-1:0]        pay2_reg;
    logic signed [BW:0]      b_s;

    assign b_s = signed'({1'b0, b_eff});

    // Stage 3: clipped position errors
    logic signed [D-1:0]     xd2, yd2, xr2, yr2, vxd2, vyd2;
    logic signed [SUMW-1:0]  exf, eyf;
    logic signed [ERR_W-1:0] ex3_reg, ey3_reg, ex3_next, ey3_next;
    logic                    sat3_reg, sat3_next;
    logic signed [D-1:0]     vxd3_reg, vyd3_reg;
    logic signed [CW-1:0]    cos3_reg, sin3_reg;

    assign {xd2, yd2, vxd2, vyd2, xr2, yr2} = pay2_reg;

    always_comb
    begin
        exf = SUMW'(xd2) - SUMW'(xr2) - SUMW'(bc2_reg >>> TRIG_OUT);
        eyf = SUMW'(yd2) - SUMW'(yr2) - SUMW'(bs2_reg >>> TRIG_OUT);
        sat3_next = 1'b0;
        if (exf > ERR_MAX)
        begin
            ex3_next  = ERR_W'(ERR_MAX);
            sat3_next = 1'b1;
        end
        else if (exf < -ERR_MAX - SUMW'(1))
        begin
            ex3_next  = ERR_W'(-ERR_MAX - SUMW'(1));
            sat3_next = 1'b1;
        end
        else
        begin
            ex3_next = ERR_W'(exf);
        end
        if (eyf > ERR_MAX)
        begin
            ey3_next  = ERR_W'(ERR_MAX);
            sat3_next = 1'b1;
        end
        else if (eyf < -ERR_MAX - SUMW'(1))
        begin
            ey3_next  = ERR_W'(-ERR_MAX - SUMW'(1));
            sat3_next = 1'b1;
        end
        else
        begin
            ey3_next = ERR_W'(eyf);
        end
    end

    // Stage 4: gain times error, split into a low unsigned and a high signed slice
    logic [PH_W-1:0]         plx4_reg, ply4_reg;
    logic signed [PH_W-1:0]  phx4_reg, phy4_reg;
    logic signed [GW:0]      g_s;
    logic signed [ERR_W-LO_W-1:0] exh, eyh;
    logic                    sat4_reg;
    logic signed [D-1:0]     vxd4_reg, vyd4_reg;
    logic signed [CW-1:0]    cos4_reg, sin4_reg;

    assign g_s = signed'({1'b0, gain_reg});
    assign exh = ex3_reg[ERR_W-1:LO_W];
    assign eyh = ey3_reg[ERR_W-1:LO_W];

    // Stage 5: recombine and scale
    logic signed [GX_W-1:0]  gxs, gys;
    logic signed [GX_W-1:0]  gx5_reg, gy5_reg;
    logic                    sat5_reg;
    logic signed [D-1:0]     vxd5_reg, vyd5_reg;
    logic signed [CW-1:0]    cos5_reg, sin5_reg;

    always_comb
    begin
        gxs = (GX_W'(phx4_reg) <<< LO_W) + signed'(GX_W'(plx4_reg));
        gys = (GX_W'(phy4_reg) <<< LO_W) + signed'(GX_W'(ply4_reg));
    end

    // Stage 6: point velocity command
    logic signed [VBF_W-1:0] vbxf, vbyf;
    logic signed [VB_W-1:0]  vbx6_reg, vby6_reg, vbx6_next, vby6_next;
    logic                    sat6_reg, sat6_next;
    logic signed [CW-1:0]    cos6_reg, sin6_reg;

    always_comb
    begin
        vbxf = VBF_W'(vxd5_reg) + VBF_W'(gx5_reg);
        vbyf = VBF_W'(vyd5_reg) + VBF_W'(gy5_reg);
        sat6_next = sat5_reg;
        if (vbxf > VB_MAX)
        begin
            vbx6_next = VB_W'(VB_MAX);
            sat6_next = 1'b1;
        end
        else if (vbxf < -VB_MAX - VBF_W'(1))
        begin
            vbx6_next = VB_W'(-VB_MAX - VBF_W'(1));
            sat6_next = 1'b1;
        end
        else
        begin
            vbx6_next = VB_W'(vbxf);
        end
        if (vbyf > VB_MAX)
        begin
            vby6_next = VB_W'(VB_MAX);
            sat6_next = 1'b1;
        end
        else if (vbyf < -VB_MAX - VBF_W'(1))
        begin
            vby6_next = VB_W'(-VB_MAX - VBF_W'(1));
            sat6_next = 1'b1;
        end
        else
        begin
            vby6_next = VB_W'(vbyf);
        end
    end

    // Stage 7: rotation products
    logic signed [PW-1:0]    pcx7_reg, psy7_reg, pcy7_reg, psx7_reg;
    logic                    sat7_reg;

    // Stage 8: linear speed and turn rate numerator
    logic signed [PS_W-1:0]  vsum, vsh, wsum, wsh;
    logic signed [D-1:0]     v8_reg, v8_next;
    logic signed [WW-1:0]    w8_reg;
    logic                    sat8_reg, sat8_next;

    always_comb
    begin
        vsum = PS_W'(pcx7_reg) + PS_W'(psy7_reg);
        wsum = PS_W'(pcy7_reg) - PS_W'(psx7_reg);
        vsh  = vsum >>> TRIG_OUT;
        wsh  = wsum >>> TRIG_OUT;
        sat8_next = sat7_reg;
        if (vsh > OUT_MAX)
        begin
            v8_next   = OMAX_D;
            sat8_next = 1'b1;
        end
        else if (vsh < -OUT_MAX - PS_W'(1))
        begin
            v8_next   = OMIN_D;
            sat8_next = 1'b1;
        end
        else
        begin
            v8_next = D'(vsh);
        end
    end

    // Stage 9: magnitude, overflow test and divider set-up
    logic [WW-1:0]           mag;
    logic                    ovf9_next;
    logic                    neg9_reg, ovf9_reg, sat9_reg;
    logic signed [D-1:0]     v9_reg;
    logic [RW-1:0]           rem9_reg;
    logic [QW-1:0]           nq9_reg;

    // The quotient only fits the output when the magnitude is below b << SHQ.
    always_comb
    begin
        mag       = w8_reg[WW-1] ? WW'(-w8_reg) : WW'(w8_reg);
        ovf9_next = mag >= (WW'(b_eff) << SHQ);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
            vld6_reg <= 1'b0;
            vld7_reg <= 1'b0;
            vld8_reg <= 1'b0;
            vld9_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld1_reg <= c_vld[TRIG_STAGES];
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
            vld5_reg <= vld4_reg;
            vld6_reg <= vld5_reg;
            vld7_reg <= vld6_reg;
            vld8_reg <= vld7_reg;
            vld9_reg <= vld8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cos1_reg <= cos1_next;
            sin1_reg <= sin1_next;
            pay1_reg <= c_pay[TRIG_STAGES];

            bc2_reg  <= b_s * cos1_reg;
            bs2_reg  <= b_s * sin1_reg;
            cos2_reg <= cos1_reg;
            sin2_reg <= sin1_reg;
            pay2_reg <= pay1_reg;

            ex3_reg  <= ex3_next;
            ey3_reg  <= ey3_next;
            sat3_reg <= sat3_next;
            vxd3_reg <= vxd2;
            vyd3_reg <= vyd2;
            cos3_reg <= cos2_reg;
            sin3_reg <= sin2_reg;

            plx4_reg <= gain_reg * ex3_reg[LO_W-1:0];
            ply4_reg <= gain_reg * ey3_reg[LO_W-1:0];
            phx4_reg <= g_s * exh;
            phy4_reg <= g_s * eyh;
            sat4_reg <= sat3_reg;
            vxd4_reg <= vxd3_reg;
            vyd4_reg <= vyd3_reg;
            cos4_reg <= cos3_reg;
            sin4_reg <= sin3_reg;

            gx5_reg  <= gxs >>> FRAC_BITS;
            gy5_reg  <= gys >>> FRAC_BITS;
            sat5_reg <= sat4_reg;
            vxd5_reg <= vxd4_reg;
            vyd5_reg <= vyd4_reg;
            cos5_reg <= cos4_reg;
            sin5_reg <= sin4_reg;

            vbx6_reg <= vbx6_next;
            vby6_reg <= vby6_next;
            sat6_reg <= sat6_next;
            cos6_reg <= cos5_reg;
            sin6_reg <= sin5_reg;

            pcx7_reg <= cos6_reg * vbx6_reg;
            psy7_reg <= sin6_reg * vby6_reg;
            pcy7_reg <= cos6_reg * vby6_reg;
            psx7_reg <= sin6_reg * vbx6_reg;
            sat7_reg <= sat6_reg;

            v8_reg   <= v8_next;
            w8_reg   <= WW'(wsh);
            sat8_reg <= sat8_next;

            neg9_reg <= w8_reg[WW-1];
            ovf9_reg <= ovf9_next;
            sat9_reg <= sat8_reg;
            v9_reg   <= v8_reg;
            rem9_reg <= RW'(mag >> SHQ);
            nq9_reg  <= QW'(mag << FRAC_BITS);
        end
    end

    // ------------------------------------------------------------------
    // Divider chain: one quotient bit per cell
    // ------------------------------------------------------------------
    logic                d_vld [QW+1];
    logic [RW-1:0]       d_rem [QW+1];
    logic [QW-1:0]       d_nq  [QW+1];
    logic [SIDE_W-1:0]   d_pay [QW+1];

    assign d_vld[0] = vld9_reg;
    assign d_rem[0] = rem9_reg;
    assign d_nq[0]  = nq9_reg;
    assign d_pay[0] = {v9_reg, sat9_reg, neg9_reg, ovf9_reg};

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        upoc_div_cell #(
            .QW    (QW),
            .PAY_W (SIDE_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .divisor (b_eff),
            .vld_in  (d_vld[k]),
            .rem_in  (d_rem[k]),
            .nq_in   (d_nq[k]),
            .pay_in  (d_pay[k]),
            .vld_out (d_vld[k+1]),
            .rem_out (d_rem[k+1]),
            .nq_out  (d_nq[k+1]),
            .pay_out (d_pay[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic signed [D-1:0] vq;
    logic                satq, negq, ovfq;
    logic [QW-1:0]       quo;
    logic signed [D-1:0] om_next;
    logic                sat_next;
    logic signed [D-1:0] speed_reg, rate_reg;
    logic                sat_reg;

    assign {vq, satq, negq, ovfq} = d_pay[QW];
    assign quo = d_nq[QW];

    always_comb
    begin
        sat_next = satq;
        if (ovfq)
        begin
            om_next  = negq ? OMIN_D : OMAX_D;
            sat_next = 1'b1;
        end
        else if (negq)
        begin
            om_next = -signed'({1'b0, quo});
        end
        else
        begin
            om_next = signed'({1'b0, quo});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= d_vld[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            speed_reg <= vq;
            rate_reg  <= om_next;
            sat_reg   <= sat_next;
        end
    end

    assign res_valid    = res_valid_reg;
    assign linear_speed = speed_reg;
    assign turn_rate    = rate_reg;
    assign saturated    = sat_reg;

endmodule

[sv/upoc_cordic_cell.sv]
// ----------------------------------------------------------------------------
// upoc_cordic_cell
// One rotation step of the heading trig chain; carries the sample alongside.
// ----------------------------------------------------------------------------
module upoc_cordic_cell
    import upoc_pkg::*;
#(
    parameter int STAGE = 0,
    parameter int PAY_W = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    vld_in,
    input  logic signed [XW-1:0]    x_in,
    input  logic signed [XW-1:0]    y_in,
    input  logic signed [ZW-1:0]    z_in,
    input  logic                    flip_in,
    input  logic [PAY_W-1:0]        pay_in,
    output logic                    vld_out,
    output logic signed [XW-1:0]    x_out,
    output logic signed [XW-1:0]    y_out,
    output logic signed [ZW-1:0]    z_out,
    output logic                    flip_out,
    output logic [PAY_W-1:0]        pay_out
);

    logic                 vld_reg;
    logic signed [XW-1:0] x_reg, y_reg, x_next, y_next, dx, dy;
    logic signed [ZW-1:0] z_reg, z_next;
    logic                 flip_reg;
    logic [PAY_W-1:0]     pay_reg;

    always_comb
    begin
        dx = y_in >>> STAGE;
        dy = x_in >>> STAGE;
        if (!z_in[ZW-1])
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ANGLE_STEP[STAGE];
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ANGLE_STEP[STAGE];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            flip_reg <= flip_in;
            pay_reg  <= pay_in;
        end
    end

    assign vld_out  = vld_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign flip_out = flip_reg;
    assign pay_out  = pay_reg;

endmodule

[sv/upoc_div_cell.sv]
// ----------------------------------------------------------------------------
// upoc_div_cell
// One restoring division step: brings down a dividend bit, yields a quotient bit.
// ----------------------------------------------------------------------------
module upoc_div_cell
    import upoc_pkg::*;
#(
    parameter int QW    = 31,
    parameter int PAY_W = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic [BW-1:0]      divisor,
    input  logic               vld_in,
    input  logic [RW-1:0]      rem_in,
    input  logic [QW-1:0]      nq_in,
    input  logic [PAY_W-1:0]   pay_in,
    output logic               vld_out,
    output logic [RW-1:0]      rem_out,
    output logic [QW-1:0]      nq_out,
    output logic [PAY_W-1:0]   pay_out
);

    logic             vld_reg;
    logic [RW-1:0]    rem_reg, rem_next;
    logic [QW-1:0]    nq_reg, nq_next;
    logic [PAY_W-1:0] pay_reg;
    logic [RW:0]      trial;
    logic             ge;

    // The top bit of nq is the next dividend bit; quotient bits enter at the bottom.
    always_comb
    begin
        trial    = {rem_in, nq_in[QW-1]};
        ge       = trial >= {2'b00, divisor};
        rem_next = ge ? RW'(trial - {2'b00, divisor}) : RW'(trial);
        nq_next  = {nq_in[QW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            nq_reg  <= nq_next;
            pay_reg <= pay_in;
        end
    end

    assign vld_out = vld_reg;
    assign rem_out = rem_reg;
    assign nq_out  = nq_reg;
    assign pay_out = pay_reg;

endmodule
